/* src/qmn_pkg.sv */
// qmn_pkg: shared constants, term tables and types for the normalized quaternion product.
// Used by qmn_front, qmn_queue, qmn_back and quaternion_multiply_normalize.
`default_nettype none
package qmn_pkg;

   localparam int COMPONENT_WIDTH_DEF = 32;
   localparam int FRACTION_BITS_DEF   = 30;

   // magnitude width after normalizing the product
   localparam int NORM_BITS  = 30;
   localparam int SQRT_WIDTH = 2 * NORM_BITS + 2;
   localparam int ROOT_STEPS = NORM_BITS + 1;

   localparam int QUEUE_DEPTH = 8;
   localparam int PTR_WIDTH   = 3;

   localparam int NUM_TERMS = 16;

   // Hamilton product: term 4*k+t of component k multiplies these two inputs
   // (0..3 = q scalar,x,y,z ; 4..7 = p scalar,x,y,z)
   localparam logic [2:0] TERM_LEFT [NUM_TERMS] = '{
      3'd0, 3'd1, 3'd2, 3'd3,
      3'd0, 3'd4, 3'd2, 3'd3,
      3'd0, 3'd4, 3'd3, 3'd1,
      3'd0, 3'd4, 3'd1, 3'd2
   };
   localparam logic [2:0] TERM_RIGHT [NUM_TERMS] = '{
      3'd4, 3'd5, 3'd6, 3'd7,
      3'd5, 3'd1, 3'd7, 3'd6,
      3'd6, 3'd2, 3'd5, 3'd7,
      3'd7, 3'd3, 3'd6, 3'd5
   };
   // bit n set: term n is subtracted
   localparam logic [NUM_TERMS-1:0] TERM_SUB = 16'b1000_1000_1000_1110;

   // queue handshake from the top level
   typedef struct packed {
      logic reserve;
      logic push;
      logic pop;
   } queue_ctrl_type;

   typedef struct packed {
      logic empty;
      logic room;
   } queue_status_type;

   // normalized magnitudes with their result signs
   typedef struct packed {
      logic [3:0][NORM_BITS-1:0] m;
      logic [3:0]                neg;
      logic                      zero;
   } norm_item_type;

endpackage
`default_nettype wire

/* src/qmn_front.sv */
// qmn_front: registers the two quaternions, forms the 16 partial products and
// sums them into the exact Hamilton product. Depends on qmn_pkg.
`default_nettype none
module qmn_front #(
   parameter int COMPONENT_WIDTH = qmn_pkg::COMPONENT_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                in_valid,
   input  wire logic [8*COMPONENT_WIDTH-1:0]        in_data,
   output logic                                     out_valid,
   output logic [4*(2*COMPONENT_WIDTH+2)-1:0]       out_data
);
   import qmn_pkg::*;

   localparam int CW    = COMPONENT_WIDTH;
   localparam int PW    = 2 * CW;
   localparam int CWIDE = 2 * CW + 2;

   logic signed [CW-1:0]    in_ff   [8];
   logic signed [PW-1:0]    prod_ff [NUM_TERMS];
   logic signed [CWIDE-1:0] sum_in  [4];
   logic signed [CWIDE-1:0] sum_ff  [4];
   logic [2:0]              valid_ff;

   // valid pipe, never stalls: the queue has room reserved per word
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   // input register
   always_ff @(posedge clock) begin
      for (int i = 0; i < 8; i++) begin
         in_ff[i] <= $signed(in_data[i*CW +: CW]);
      end
   end

   // partial products
   always_ff @(posedge clock) begin
      for (int t = 0; t < NUM_TERMS; t++) begin
         prod_ff[t] <= in_ff[TERM_LEFT[t]] * in_ff[TERM_RIGHT[t]];
      end
   end

   // four-term sums, exact
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         sum_in[k] = '0;
         for (int t = 0; t < 4; t++) begin
            if (TERM_SUB[4*k+t]) begin
               sum_in[k] = sum_in[k] - CWIDE'(prod_ff[4*k+t]);
            end else begin
               sum_in[k] = sum_in[k] + CWIDE'(prod_ff[4*k+t]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         sum_ff[k] <= sum_in[k];
      end
   end

   assign out_valid = valid_ff[2];
   for (genvar k = 0; k < 4; k++) begin : g_pack
      assign out_data[k*CWIDE +: CWIDE] = sum_ff[k];
   end

endmodule
`default_nettype wire

/* src/qmn_queue.sv */
// qmn_queue: short word queue between front and back, with a reservation count
// that covers words still in the front pipe. Depends on qmn_pkg.
`default_nettype none
module qmn_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire qmn_pkg::queue_ctrl_type     ctrl,
   input  wire logic [WIDTH-1:0]            push_data,
   output logic [WIDTH-1:0]                 pop_data,
   output qmn_pkg::queue_status_type        status
);
   import qmn_pkg::*;

   logic [WIDTH-1:0]     mem_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_WIDTH:0]   fill_ff, fill_in;
   logic [PTR_WIDTH:0]   resv_ff, resv_in;

   always_comb begin
      fill_in = fill_ff + (PTR_WIDTH+1)'(ctrl.push) - (PTR_WIDTH+1)'(ctrl.pop);
      resv_in = resv_ff + (PTR_WIDTH+1)'(ctrl.reserve) - (PTR_WIDTH+1)'(ctrl.pop);
   end

   // pointers and counts
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
         resv_ff   <= '0;
      end else begin
         if (ctrl.push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (ctrl.pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         fill_ff <= fill_in;
         resv_ff <= resv_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (ctrl.push) mem_ff[wr_ptr_ff] <= push_data;
   end

   assign pop_data     = mem_ff[rd_ptr_ff];
   assign status.empty = (fill_ff == '0);
   assign status.room  = (resv_ff < (PTR_WIDTH+1)'(QUEUE_DEPTH));

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.push && !ctrl.pop && fill_ff == (PTR_WIDTH+1)'(QUEUE_DEPTH)))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.pop && fill_ff == '0))
      else $error("queue read while empty");
   a_fill_covered: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= resv_ff)
      else $error("queue fill exceeds reservations");
`endif

endmodule
`default_nettype wire

/* src/qmn_back.sv */
// qmn_back: normalizes the product: sign fold, leading-one search, shift,
// pipelined integer square root and per-bit restoring divide. Depends on qmn_pkg.
`default_nettype none
module qmn_back #(
   parameter int COMPONENT_WIDTH = qmn_pkg::COMPONENT_WIDTH_DEF,
   parameter int FRACTION_BITS   = qmn_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   input  wire logic [4*(2*COMPONENT_WIDTH+2)-1:0] in_data,
   output logic                                   in_pop,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output logic [4*COMPONENT_WIDTH-1:0]           out_data,
   output logic                                   out_zero
);
   import qmn_pkg::*;

   localparam int CW        = COMPONENT_WIDTH;
   localparam int CWIDE     = 2 * CW + 2;
   localparam int MW        = CWIDE - 1;
   localparam int LW        = $clog2(MW + 1);
   localparam int SW        = SQRT_WIDTH;
   localparam int SQW       = 2 * NORM_BITS;
   localparam int NW        = NORM_BITS + 1;
   localparam int DW        = NORM_BITS + 2;
   localparam int QW        = FRACTION_BITS + 2;
   localparam int XW        = ((QW > CW) ? QW : CW) + 1;
   localparam int DIV_STEPS = FRACTION_BITS + 1;
   localparam int NV        = 7 + ROOT_STEPS + DIV_STEPS;
   localparam logic [XW-1:0] POS_MAX = XW'({(CW-1){1'b1}});

   typedef struct packed {
      norm_item_type   it;
      logic [SW-1:0]   s;
      logic [SW-1:0]   res;
   } root_type;

   typedef struct packed {
      logic [3:0]          neg;
      logic                zero;
      logic [NW-1:0]       nrm;
      logic [3:0][DW-1:0]  rem;
      logic [3:0][QW-1:0]  q;
   } div_type;

   logic                    en;
   logic [NV-1:0]           v_ff;
   logic signed [CWIDE-1:0] c_ff   [4];
   logic [MW-1:0]           mag_ff [4];
   logic [3:0]              neg_ff;
   logic [MW-1:0]           or_ff;
   logic [MW-1:0]           mag2_ff [4];
   logic [3:0]              neg2_ff;
   logic [LW-1:0]           l_in, l_ff;
   norm_item_type           norm_in, norm_ff;
   logic [SQW-1:0]          sqr_ff [4];
   norm_item_type           norm2_ff;
   root_type                root_ff [ROOT_STEPS+1];
   div_type                 div_ff  [DIV_STEPS+1];
   logic [4*CW-1:0]         rsp_in, rsp_ff;
   logic                    zero_in, zero_ff, out_valid_ff;

   // whole pipe advances unless the result register holds an untaken word
   assign en     = !out_valid_ff || out_ready;
   assign in_pop = en && in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         v_ff         <= {v_ff[NV-2:0], in_pop};
         out_valid_ff <= v_ff[NV-1];
      end
   end

   // product word from the queue
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            c_ff[k] <= $signed(in_data[k*CWIDE +: CWIDE]);
         end
      end
   end

   // magnitudes; signs folded so the scalar comes out non-negative
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            mag_ff[k] <= c_ff[k][CWIDE-1] ? MW'(-c_ff[k]) : MW'(c_ff[k]);
            neg_ff[k] <= c_ff[k][CWIDE-1] ^ c_ff[0][CWIDE-1];
         end
         or_ff <= (c_ff[0][CWIDE-1] ? MW'(-c_ff[0]) : MW'(c_ff[0]))
                | (c_ff[1][CWIDE-1] ? MW'(-c_ff[1]) : MW'(c_ff[1]))
                | (c_ff[2][CWIDE-1] ? MW'(-c_ff[2]) : MW'(c_ff[2]))
                | (c_ff[3][CWIDE-1] ? MW'(-c_ff[3]) : MW'(c_ff[3]));
      end
   end

   // bit length of the largest magnitude
   always_comb begin
      l_in = '0;
      for (int i = 0; i < MW; i++) begin
         if (or_ff[i]) l_in = LW'(i + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l_ff    <= l_in;
         mag2_ff <= mag_ff;
         neg2_ff <= neg_ff;
      end
   end

   // normalizing shift
   always_comb begin
      norm_in.neg  = neg2_ff;
      norm_in.zero = (l_ff == '0);
      for (int k = 0; k < 4; k++) begin
         if (l_ff > LW'(NORM_BITS)) begin
            norm_in.m[k] = NORM_BITS'(mag2_ff[k] >> (l_ff - LW'(NORM_BITS)));
         end else begin
            norm_in.m[k] = NORM_BITS'(mag2_ff[k] << (LW'(NORM_BITS) - l_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) norm_ff <= norm_in;
   end

   // squares, then their sum seeds the root
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            sqr_ff[k] <= SQW'(norm_ff.m[k]) * SQW'(norm_ff.m[k]);
         end
         norm2_ff <= norm_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         root_ff[0].it  <= norm2_ff;
         root_ff[0].s   <= SW'(sqr_ff[0]) + SW'(sqr_ff[1]) + SW'(sqr_ff[2])
                         + SW'(sqr_ff[3]);
         root_ff[0].res <= '0;
      end
   end

   // integer square root, one result bit per stage
   for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_root
      localparam logic [SW-1:0] RBIT = SW'(1) << (2 * (ROOT_STEPS - 1 - i));
      root_type      root_in;
      logic [SW-1:0] trial;
      always_comb begin
         root_in = root_ff[i];
         trial   = root_ff[i].res + RBIT;
         if (root_ff[i].s >= trial) begin
            root_in.s   = root_ff[i].s - trial;
            root_in.res = (root_ff[i].res >> 1) + RBIT;
         end else begin
            root_in.res = root_ff[i].res >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (en) root_ff[i+1] <= root_in;
      end
   end

   // divide setup
   always_ff @(posedge clock) begin
      if (en) begin
         div_ff[0].neg  <= root_ff[ROOT_STEPS].it.neg;
         div_ff[0].zero <= root_ff[ROOT_STEPS].it.zero;
         div_ff[0].nrm  <= NW'(root_ff[ROOT_STEPS].res);
         for (int k = 0; k < 4; k++) begin
            div_ff[0].rem[k] <= DW'(root_ff[ROOT_STEPS].it.m[k]);
            div_ff[0].q[k]   <= '0;
         end
      end
   end

   // restoring divide, one quotient bit per stage, four lanes
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      div_type       div_in;
      logic [DW-1:0] r2 [4];
      always_comb begin
         div_in = div_ff[j];
         for (int k = 0; k < 4; k++) begin
            r2[k] = (j == 0) ? div_ff[j].rem[k] : {div_ff[j].rem[k][DW-2:0], 1'b0};
            if (r2[k] >= DW'(div_ff[j].nrm)) begin
               div_in.rem[k] = r2[k] - DW'(div_ff[j].nrm);
               div_in.q[k]   = {div_ff[j].q[k][QW-2:0], 1'b1};
            end else begin
               div_in.rem[k] = r2[k];
               div_in.q[k]   = {div_ff[j].q[k][QW-2:0], 1'b0};
            end
         end
      end
      always_ff @(posedge clock) begin
         if (en) div_ff[j+1] <= div_in;
      end
   end

   // round half up, saturate, apply sign
   always_comb begin
      logic [QW-1:0] qr;
      logic [XW-1:0] qx;
      logic [CW-1:0] val;
      rsp_in  = '0;
      zero_in = div_ff[DIV_STEPS].zero;
      for (int k = 0; k < 4; k++) begin
         qr = div_ff[DIV_STEPS].q[k];
         if ({div_ff[DIV_STEPS].rem[k], 1'b0} >= (DW+1)'(div_ff[DIV_STEPS].nrm)) begin
            qr = qr + 1'b1;
         end
         qx = XW'(qr);
         if (qx > POS_MAX) qx = POS_MAX;
         val = CW'(qx);
         if (div_ff[DIV_STEPS].neg[k]) val = -val;
         if (!div_ff[DIV_STEPS].zero) rsp_in[k*CW +: CW] = val;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff  <= rsp_in;
         zero_ff <= zero_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = rsp_ff;
   assign out_zero  = zero_ff;

endmodule
`default_nettype wire

/* src/quaternion_multiply_normalize.sv */
// quaternion_multiply_normalize: top level; front product pipe, word queue,
// normalizing back pipe. Depends on qmn_pkg, qmn_front, qmn_queue, qmn_back.
`default_nettype none
// Takes one word with two quaternions per cycle while there is queue room and
// returns their Hamilton product, sign-folded so the scalar is non-negative
// and scaled to unit norm, one word per cycle while the response side is ready.
// A request passes the input, product and sum registers and the queue write,
// then 70 back stages at defaults: 6 for fold, shift and squares, 31 root
// stages, FRACTION_BITS + 2 divide stages and the response register. The
// queue holds 8 words; the request side stalls only when the back pipe is
// held by the response side long enough to fill it. A zero product returns
// all-zero components with tuser set.
module quaternion_multiply_normalize #(
   parameter int COMPONENT_WIDTH = qmn_pkg::COMPONENT_WIDTH_DEF,
   parameter int FRACTION_BITS   = qmn_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // q_scalar, q_vx, q_vy, q_vz, p_scalar, p_vx, p_vy, p_vz
   input  wire logic [8*COMPONENT_WIDTH-1:0]  req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // r_scalar, r_vx, r_vy, r_vz
   output logic [4*COMPONENT_WIDTH-1:0]       rsp_tdata,
   // zero_norm
   output logic                               rsp_tuser
);
   import qmn_pkg::*;

   localparam int CWIDE = 2 * COMPONENT_WIDTH + 2;

   queue_ctrl_type           qctrl;
   queue_status_type         qstat;
   logic                     front_valid;
   logic [4*CWIDE-1:0]       front_data;
   logic [4*CWIDE-1:0]       queue_data;
   logic                     back_pop;

   assign req_tready    = qstat.room;
   assign qctrl.reserve = req_tvalid && req_tready;
   assign qctrl.push    = front_valid;
   assign qctrl.pop     = back_pop;

   qmn_front #(
      .COMPONENT_WIDTH (COMPONENT_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (qctrl.reserve),
      .in_data   (req_tdata),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   qmn_queue #(
      .WIDTH (4*CWIDE)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (qctrl),
      .push_data (front_data),
      .pop_data  (queue_data),
      .status    (qstat)
   );

   qmn_back #(
      .COMPONENT_WIDTH (COMPONENT_WIDTH),
      .FRACTION_BITS   (FRACTION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (!qstat.empty),
      .in_data   (queue_data),
      .in_pop    (back_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata),
      .out_zero  (rsp_tuser)
   );

endmodule
`default_nettype wire
